>>> hw/rtl/fws_pkg.sv
// Shared types for the sorted-insert queue: operation codes and the
// control word broadcast to every cell of the storage row.
// No dependencies.
`default_nettype none

package fws_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned CAPACITY = 16;

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_SORTED = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    // Broadcast to all cells each cycle
    typedef struct packed {
        logic                       en;     // commit the operation this cycle
        t_func                      func;
        logic signed [VALUE_W-1:0]  value;
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> hw/rtl/fifo_with_sorted_insert.sv
// Bounded queue of signed 32-bit values with append, sorted insert,
// remove-head and clear. Top level; depends on fws_pkg and fws_cell.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one operation per beat:
//   i_func selects append, sorted insert, remove head or clear, and
//   i_value is the operand for the two insert forms.
//   Output channel (o_valid / i_stall) returns one result beat per input
//   beat: ok flag, removed head value, count, empty/full flags and the head
//   and tail values after the operation.
//   Latency: the result is presented the cycle after the input beat.
//   Throughput: one operation per cycle while the output is not stalled. Every cell compares in parallel and
//   a found bit ripples along the row of CAPACITY cells in the same cycle;
//   that ripple sets the clock period.
//   Stall: the single result register holds while i_stall is high; the input
//   side stalls only while that register is full and being held, and a new
//   beat is taken in the same cycle the held result leaves.
//   Reset: clears the count and the result valid flag; the queue is empty and
//   no result is pending. Cell contents are not reset (never read while empty).
//   Refused operations (insert when full, remove when empty) report ok=0 and
//   leave the queue unchanged. Count is reported modulo 32.
`default_nettype none

module fifo_with_sorted_insert #(
    parameter int unsigned CAPACITY = fws_pkg::CAPACITY
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // input channel
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic [1:0]                             i_func,
    input  wire logic signed [fws_pkg::VALUE_W-1:0]     i_value,
    // output channel
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic                                        o_ok,
    output logic signed [fws_pkg::VALUE_W-1:0]          o_removed_value,
    output logic [fws_pkg::COUNT_W-1:0]                 o_count,
    output logic                                        o_empty_res,
    output logic                                        o_full_res,
    output logic signed [fws_pkg::VALUE_W-1:0]          o_head_value,
    output logic signed [fws_pkg::VALUE_W-1:0]          o_tail_value
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    logic [CNT_W-1:0]                       r_count;
    logic [CNT_W-1:0]                       n_count;
    logic                                   r_out_valid;
    logic                                   r_ok;
    logic                                   n_ok;
    logic signed [fws_pkg::VALUE_W-1:0]     r_removed;
    logic signed [fws_pkg::VALUE_W-1:0]     n_removed;
    // tail tracked beside the row so it needs no wide read mux
    logic signed [fws_pkg::VALUE_W-1:0]     r_tail;
    logic signed [fws_pkg::VALUE_W-1:0]     n_tail;

    fws_pkg::t_func                         func;
    fws_pkg::t_cell_ctrl                    ctrl;
    logic                                   accept;
    logic                                   is_full;
    logic                                   is_empty;
    logic                                   any_hit;

    // Cell row wiring
    logic signed [fws_pkg::VALUE_W-1:0]     cell_value [CAPACITY];
    logic                                   found_chain [CAPACITY+1];
    logic [CAPACITY-1:0]                    occ_hit;

    assign func     = fws_pkg::t_func'(i_func);
    assign o_stall  = r_out_valid && i_stall;
    assign accept   = i_valid && !o_stall;
    assign is_full  = r_count == CNT_W'(CAPACITY);
    assign is_empty = r_count == '0;
    assign any_hit  = |occ_hit;

    // ---------------------------------------------------------------
    // Operation decode: success, count, tail and removed value
    // ---------------------------------------------------------------
    always_comb begin
        n_ok      = 1'b0;
        n_count   = r_count;
        n_tail    = r_tail;
        n_removed = '0;
        case (func)
            fws_pkg::FUNC_APPEND: begin
                if (!is_full) begin
                    n_ok    = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    n_tail  = i_value;
                end
            end
            fws_pkg::FUNC_SORTED: begin
                if (!is_full) begin
                    n_ok    = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    // lands at the tail only when no stored entry is >= value
                    n_tail  = any_hit ? r_tail : i_value;
                end
            end
            fws_pkg::FUNC_REMOVE: begin
                if (!is_empty) begin
                    n_ok      = 1'b1;
                    n_count   = r_count - CNT_W'(1);
                    n_removed = cell_value[0];
                end
            end
            default: begin
                n_ok    = 1'b1;
                n_count = '0;
            end
        endcase
    end

    assign ctrl.en    = accept && n_ok;
    assign ctrl.func  = func;
    assign ctrl.value = i_value;

    // ---------------------------------------------------------------
    // Storage row: cell 0 is the head
    // ---------------------------------------------------------------
    assign found_chain[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [fws_pkg::VALUE_W-1:0] left_val;
        logic signed [fws_pkg::VALUE_W-1:0] right_val;

        if (g == 0) begin : g_head
            assign left_val = '0;
        end else begin : g_mid
            assign left_val = cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_inner
            assign right_val = cell_value[g+1];
        end

        fws_cell #(
            .IDX     (g),
            .COUNT_W (CNT_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (ctrl),
            .i_count   (r_count),
            .i_left    (left_val),
            .i_right   (right_val),
            .i_found   (found_chain[g]),
            .o_found   (found_chain[g+1]),
            .o_occ_hit (occ_hit[g]),
            .o_value   (cell_value[g])
        );
    end

    // ---------------------------------------------------------------
    // State and result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok      <= n_ok;
            r_removed <= n_removed;
            r_tail    <= n_tail;
        end
    end

    // Head/tail/count come straight from the queue state; it only changes
    // when a new beat is accepted, i.e. when the result register reloads.
    assign o_valid         = r_out_valid;
    assign o_ok            = r_ok;
    assign o_removed_value = r_removed;
    assign o_count         = fws_pkg::COUNT_W'(r_count);
    assign o_empty_res     = is_empty;
    assign o_full_res      = is_full;
    assign o_head_value    = is_empty ? '0 : cell_value[0];
    assign o_tail_value    = is_empty ? '0 : r_tail;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("count exceeds capacity");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted beat produced no result");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && func == fws_pkg::FUNC_CLEAR) |=> (o_ok && o_empty_res))
        else $error("clear did not empty the queue");

    a_refused_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !n_ok) |=> (r_count == $past(r_count)))
        else $error("refused operation changed the count");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_ok && (func == fws_pkg::FUNC_APPEND || func == fws_pkg::FUNC_SORTED))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("successful insert did not grow the count");

endmodule

`default_nettype wire

>>> hw/rtl/fws_cell.sv
// One storage cell of the queue row: holds a value, compares it against the
// broadcast value and shifts left or right with its neighbors.
// Depends on fws_pkg.
`default_nettype none

module fws_cell #(
    parameter int unsigned IDX     = 0,
    parameter int unsigned COUNT_W = 5
) (
    input  wire logic                                    i_clk,
    input  wire fws_pkg::t_cell_ctrl                     i_ctrl,
    input  wire logic [COUNT_W-1:0]                      i_count,
    input  wire logic signed [fws_pkg::VALUE_W-1:0]      i_left,
    input  wire logic signed [fws_pkg::VALUE_W-1:0]      i_right,
    input  wire logic                                    i_found,
    output logic                                         o_found,
    output logic                                         o_occ_hit,
    output logic signed [fws_pkg::VALUE_W-1:0]           o_value
);

    logic signed [fws_pkg::VALUE_W-1:0] r_value;
    logic signed [fws_pkg::VALUE_W-1:0] n_value;
    logic                               occupied;
    logic                               at_tail;
    logic                               hit;

    assign occupied  = COUNT_W'(IDX) < i_count;
    assign at_tail   = COUNT_W'(IDX) == i_count;
    assign o_occ_hit = (i_ctrl.func == fws_pkg::FUNC_SORTED) && occupied
                       && (i_ctrl.value <= r_value);
    // first free slot terminates the search for both append and insert
    assign hit       = o_occ_hit || at_tail;
    assign o_found   = i_found || hit;
    assign o_value   = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.en) begin
            case (i_ctrl.func)
                fws_pkg::FUNC_APPEND, fws_pkg::FUNC_SORTED: begin
                    if (i_found) begin
                        n_value = i_left;          // make room: shift toward tail
                    end else if (hit) begin
                        n_value = i_ctrl.value;
                    end
                end
                fws_pkg::FUNC_REMOVE: begin
                    n_value = i_right;             // shift toward head
                end
                default: begin
                    n_value = r_value;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire
